FILE: rtl/ptd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// shared widths, microcode types and step addresses for the trial division
// primality tester
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int INPUT_WIDTH = 64;
    localparam int VALUE_WIDTH = 64;
    localparam int ROOT_WIDTH  = (VALUE_WIDTH + 1) / 2;
    localparam int SHIFT_WIDTH = 2 * ROOT_WIDTH;
    localparam int ACC_WIDTH   = ROOT_WIDTH + 3;
    localparam int COUNT_WIDTH = $clog2(SHIFT_WIDTH + 1);
    localparam int PC_WIDTH    = 4;

    typedef logic [PC_WIDTH-1:0] pc_t;

    localparam pc_t STEP_WAIT      = 4'd0;
    localparam pc_t STEP_SMALL     = 4'd1;
    localparam pc_t STEP_ROOT_INIT = 4'd2;
    localparam pc_t STEP_ROOT      = 4'd3;
    localparam pc_t STEP_DIV_SET   = 4'd4;
    localparam pc_t STEP_TRY       = 4'd5;
    localparam pc_t STEP_DIV_INIT  = 4'd6;
    localparam pc_t STEP_DIV       = 4'd7;
    localparam pc_t STEP_TEST      = 4'd8;
    localparam pc_t STEP_NEXT      = 4'd9;
    localparam pc_t STEP_COMPOSITE = 4'd10;
    localparam pc_t STEP_EMIT      = 4'd11;
    localparam pc_t STEP_RETURN    = 4'd12;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_VERDICT_CLR,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_DIV_SET,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_NEXT,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_N_BELOW_TWO,
        C_D_BELOW_TWO,
        C_COUNT_LIVE,
        C_REM_ZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic n_below_two;
        logic d_below_two;
        logic count_live;
        logic rem_zero;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

FILE: rtl/ptd_urom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_urom
// microcode table: one control word per step address
// ----------------------------------------------------------------------------
module ptd_urom (
    input  wire ptd_pkg::pc_t   pc,
    output ptd_pkg::ctrl_t      ctl
);
    import ptd_pkg::*;

    always_comb
    begin
        unique case (pc)
            STEP_WAIT:      ctl = '{op: OP_LOAD,        cond: C_NO_INPUT,    target: STEP_WAIT};
            STEP_SMALL:     ctl = '{op: OP_VERDICT_CLR, cond: C_N_BELOW_TWO, target: STEP_EMIT};
            STEP_ROOT_INIT: ctl = '{op: OP_ROOT_INIT,   cond: C_NEVER,       target: STEP_WAIT};
            STEP_ROOT:      ctl = '{op: OP_ROOT_STEP,   cond: C_COUNT_LIVE,  target: STEP_ROOT};
            STEP_DIV_SET:   ctl = '{op: OP_DIV_SET,     cond: C_NEVER,       target: STEP_WAIT};
            STEP_TRY:       ctl = '{op: OP_NOP,         cond: C_D_BELOW_TWO, target: STEP_EMIT};
            STEP_DIV_INIT:  ctl = '{op: OP_DIV_INIT,    cond: C_NEVER,       target: STEP_WAIT};
            STEP_DIV:       ctl = '{op: OP_DIV_STEP,    cond: C_COUNT_LIVE,  target: STEP_DIV};
            STEP_TEST:      ctl = '{op: OP_NOP,         cond: C_REM_ZERO,    target: STEP_COMPOSITE};
            STEP_NEXT:      ctl = '{op: OP_DIV_NEXT,    cond: C_ALWAYS,      target: STEP_TRY};
            STEP_COMPOSITE: ctl = '{op: OP_VERDICT_CLR, cond: C_NEVER,       target: STEP_WAIT};
            STEP_EMIT:      ctl = '{op: OP_EMIT,        cond: C_OUT_BUSY,    target: STEP_EMIT};
            STEP_RETURN:    ctl = '{op: OP_NOP,         cond: C_ALWAYS,      target: STEP_WAIT};
            default:        ctl = '{op: OP_NOP,         cond: C_ALWAYS,      target: STEP_WAIT};
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/ptd_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_sequencer
// step counter with conditional jumps on datapath status
// ----------------------------------------------------------------------------
module ptd_sequencer (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire ptd_pkg::ctrl_t ctl,
    input  wire ptd_pkg::stat_t stat,
    output ptd_pkg::pc_t        pc
);
    import ptd_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic taken;

    always_comb
    begin
        unique case (ctl.cond)
            C_NEVER:       taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NO_INPUT:    taken = !in_valid;
            C_N_BELOW_TWO: taken = stat.n_below_two;
            C_D_BELOW_TWO: taken = stat.d_below_two;
            C_COUNT_LIVE:  taken = stat.count_live;
            C_REM_ZERO:    taken = stat.rem_zero;
            C_OUT_BUSY:    taken = stat.out_busy;
            default:       taken = 1'b0;
        endcase
        pc_next = taken ? ctl.target : pc_t'(pc_reg + pc_t'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign pc = pc_reg;

endmodule
`default_nettype wire

FILE: rtl/ptd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_datapath
// bit-serial floor root and remainder unit, divisor counter, result register
// ----------------------------------------------------------------------------
module ptd_datapath (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire ptd_pkg::ctrl_t                  ctl,
    input  wire                                  in_valid,
    input  wire [ptd_pkg::INPUT_WIDTH-1:0]       number,
    input  wire                                  out_ready,
    output logic                                 out_valid,
    output logic                                 is_prime,
    output ptd_pkg::stat_t                       stat
);
    import ptd_pkg::*;

    logic [SHIFT_WIDTH-1:0] n_reg;
    logic [SHIFT_WIDTH-1:0] n_next;
    logic [SHIFT_WIDTH-1:0] sh_reg;
    logic [SHIFT_WIDTH-1:0] sh_next;
    logic [ACC_WIDTH-1:0]   acc_reg;
    logic [ACC_WIDTH-1:0]   acc_next;
    logic [ROOT_WIDTH-1:0]  root_reg;
    logic [ROOT_WIDTH-1:0]  root_next;
    logic [ROOT_WIDTH-1:0]  d_reg;
    logic [ROOT_WIDTH-1:0]  d_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   verdict_reg;
    logic                   verdict_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   is_prime_reg;
    logic                   is_prime_next;

    logic [ACC_WIDTH-1:0]   root_rem;
    logic [ACC_WIDTH-1:0]   root_trial;
    logic [ROOT_WIDTH:0]    div_rem;
    logic [ROOT_WIDTH:0]    div_d;
    logic                   out_busy;
    logic                   emit;

    // one root bit per step
    assign root_rem   = {acc_reg[ACC_WIDTH-3:0], sh_reg[SHIFT_WIDTH-1 -: 2]};
    assign root_trial = {1'b0, root_reg, 2'b01};

    // one quotient bit per step
    assign div_rem = {acc_reg[ROOT_WIDTH-1:0], sh_reg[SHIFT_WIDTH-1]};
    assign div_d   = {1'b0, d_reg};

    assign out_busy = out_valid_reg && !out_ready;
    assign emit     = (ctl.op == OP_EMIT) && !out_busy;

    always_comb
    begin
        n_next       = n_reg;
        sh_next      = sh_reg;
        acc_next     = acc_reg;
        root_next    = root_reg;
        d_next       = d_reg;
        count_next   = count_reg;
        verdict_next = verdict_reg;
        unique case (ctl.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    n_next = SHIFT_WIDTH'(number[VALUE_WIDTH-1:0]);
                end
            end
            OP_VERDICT_CLR:
            begin
                verdict_next = 1'b0;
            end
            OP_ROOT_INIT:
            begin
                acc_next   = '0;
                root_next  = '0;
                sh_next    = n_reg;
                count_next = COUNT_WIDTH'(ROOT_WIDTH);
            end
            OP_ROOT_STEP:
            begin
                if (root_rem >= root_trial)
                begin
                    acc_next  = root_rem - root_trial;
                    root_next = {root_reg[ROOT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next  = root_rem;
                    root_next = {root_reg[ROOT_WIDTH-2:0], 1'b0};
                end
                sh_next    = {sh_reg[SHIFT_WIDTH-3:0], 2'b00};
                count_next = count_reg - COUNT_WIDTH'(1);
            end
            OP_DIV_SET:
            begin
                d_next       = root_reg;
                verdict_next = 1'b1;
            end
            OP_DIV_INIT:
            begin
                acc_next   = '0;
                sh_next    = n_reg;
                count_next = COUNT_WIDTH'(SHIFT_WIDTH);
            end
            OP_DIV_STEP:
            begin
                if (div_rem >= div_d)
                begin
                    acc_next = ACC_WIDTH'(div_rem - div_d);
                end
                else
                begin
                    acc_next = ACC_WIDTH'(div_rem);
                end
                sh_next    = {sh_reg[SHIFT_WIDTH-2:0], 1'b0};
                count_next = count_reg - COUNT_WIDTH'(1);
            end
            OP_DIV_NEXT:
            begin
                d_next = d_reg - ROOT_WIDTH'(1);
            end
            OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            is_prime_next  = verdict_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        sh_reg       <= sh_next;
        acc_reg      <= acc_next;
        root_reg     <= root_next;
        d_reg        <= d_next;
        count_reg    <= count_next;
        verdict_reg  <= verdict_next;
        is_prime_reg <= is_prime_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    assign stat.n_below_two = (n_reg[SHIFT_WIDTH-1:1] == '0);
    assign stat.d_below_two = (d_reg[ROOT_WIDTH-1:1] == '0);
    assign stat.count_live  = (count_reg != COUNT_WIDTH'(1));
    assign stat.rem_zero    = (acc_reg == '0);
    assign stat.out_busy    = out_busy;

endmodule
`default_nettype wire

FILE: rtl/primality_trial_division.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// primality_trial_division
// trial division primality test run by a microcoded sequencer
//
//   channel | signals                      | word
//   --------+------------------------------+-----------------------------
//   in      | in_valid, in_ready, number   | 64-bit unsigned value
//   out     | out_valid, out_ready, is_prime | 1 when the value is prime
//
// per word: W = ROOT_WIDTH (32) root steps give R = floor root, then each trial
// divisor from R down to 2 takes S = SHIFT_WIDTH (64) quotient steps in the
// shared remainder unit, one quotient bit per cycle
// a composite stops at its largest divisor not above R
// values below 2 skip the root and the trial divisions and are not prime
// one word in flight; the next word is taken while a result waits in the
// output register
// reset clears the step counter and the output valid
// ----------------------------------------------------------------------------
module primality_trial_division (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire [ptd_pkg::INPUT_WIDTH-1:0]      number,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                is_prime
);
    import ptd_pkg::*;

    pc_t   pc;
    ctrl_t ctl;
    stat_t stat;

    ptd_urom u_urom (
        .pc  (pc),
        .ctl (ctl)
    );

    ptd_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .ctl      (ctl),
        .stat     (stat),
        .pc       (pc)
    );

    ptd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_valid  (in_valid),
        .number    (number),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .is_prime  (is_prime),
        .stat      (stat)
    );

    assign in_ready = (ctl.op == OP_LOAD);

    // one word at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while one is in work");

    // a result appears only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.op == OP_EMIT))
        else $error("result raised outside the emit step");

    // never divide by zero or one
    a_divisor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_DIV_STEP) |-> !stat.d_below_two)
        else $error("remainder step with divisor below two");

endmodule
`default_nettype wire
